### sv/cat_pkg.sv
// types and constants shared by the caller allow-list table
package cat_pkg;

    localparam int TABLE_ENTRIES = 8;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    localparam int NUM_W = 32;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 8;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_CHECK  = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_NOT_INIT = 2'd1,
        STAT_INVALID  = 2'd2,
        STAT_FULL     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } state_t;

endpackage

### sv/caller_allowlist_table.sv
// allow-list table of 32-bit numbers with a one-slot-per-cycle scan sequencer
//
//  channel  | direction | beat fields (lsb up)              | handshake
//  ---------+-----------+-----------------------------------+---------------------
//  s_       | in        | cmd[1:0], number[33:2], pad       | s_tvalid / s_tready
//  m_       | out       | status[1:0], allowed[2], pad      | m_tvalid / m_tready
//  cfg_     | in        | initialized                       | cfg_we, no wait
//
// not initialised, clear and zero-number beats give their result in the cycle after
// acceptance; add, remove and check scan the table through one shared comparator,
// one slot per cycle.
// synchronous active-low reset frees every slot at once through per-slot valid bits.
// s_tready is low while a scan runs or while a result is held and not taken.
module caller_allowlist_table (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic                           cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [cat_pkg::S_TDATA_W-1:0]  s_tdata,   // cmd[1:0], number[33:2], zero pad
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [cat_pkg::M_TDATA_W-1:0]  m_tdata    // status[1:0], allowed[2], zero pad
);

    cat_pkg::state_t                   state_reg, state_next;
    logic [cat_pkg::IDX_W-1:0]         idx_reg, idx_next;
    cat_pkg::cmd_t                     cmd_reg, cmd_next;
    logic [cat_pkg::NUM_W-1:0]         num_reg, num_next;
    logic                              found_reg, found_next;
    logic                              used_reg, used_next;
    logic [cat_pkg::TABLE_ENTRIES-1:0] valid_reg, valid_next;
    logic [cat_pkg::NUM_W-1:0]         table_reg [cat_pkg::TABLE_ENTRIES];
    logic [cat_pkg::NUM_W-1:0]         rd_word_reg;
    logic                              init_reg;
    logic                              m_valid_reg, m_valid_next;
    cat_pkg::status_t                  m_status_reg, m_status_next;
    logic                              m_allowed_reg, m_allowed_next;

    logic                              accept;
    logic                              out_free;
    logic                              tbl_we;
    logic                              slot_used;
    logic                              slot_match;
    logic                              last_slot;
    cat_pkg::cmd_t                     s_cmd;
    logic [cat_pkg::NUM_W-1:0]         s_number;

    assign s_cmd    = cat_pkg::cmd_t'(s_tdata[1:0]);
    assign s_number = s_tdata[33:2];

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == cat_pkg::S_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    // shared compare unit on the slot under the scan pointer
    assign slot_used  = valid_reg[idx_reg];
    assign slot_match = slot_used && (rd_word_reg == num_reg);
    assign last_slot  = (idx_reg == cat_pkg::LAST_IDX);

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, m_allowed_reg, m_status_reg};

    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        cmd_next       = cmd_reg;
        num_next       = num_reg;
        found_next     = found_reg;
        used_next      = used_reg;
        valid_next     = valid_reg;
        m_valid_next   = m_valid_reg;
        m_status_next  = m_status_reg;
        m_allowed_next = m_allowed_reg;
        tbl_we         = 1'b0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            cat_pkg::S_IDLE: begin
                if (accept) begin
                    cmd_next       = s_cmd;
                    num_next       = s_number;
                    idx_next       = '0;
                    found_next     = 1'b0;
                    used_next      = 1'b0;
                    m_allowed_next = 1'b0;
                    if (!init_reg) begin
                        m_valid_next  = 1'b1;
                        m_status_next = cat_pkg::STAT_NOT_INIT;
                    end else if (s_cmd == cat_pkg::CMD_CLEAR) begin
                        valid_next    = '0;
                        m_valid_next  = 1'b1;
                        m_status_next = cat_pkg::STAT_OK;
                    end else if (s_number == '0) begin
                        m_valid_next  = 1'b1;
                        m_status_next = cat_pkg::STAT_INVALID;
                    end else begin
                        state_next = cat_pkg::S_SCAN;
                    end
                end
            end
            cat_pkg::S_SCAN: begin
                idx_next = idx_reg + 1'b1;
                case (cmd_reg)
                    cat_pkg::CMD_ADD: begin
                        if (!slot_used) begin
                            tbl_we              = 1'b1;
                            valid_next[idx_reg] = 1'b1;
                            m_valid_next        = 1'b1;
                            m_status_next       = cat_pkg::STAT_OK;
                            state_next          = cat_pkg::S_IDLE;
                        end else if (last_slot) begin
                            m_valid_next  = 1'b1;
                            m_status_next = cat_pkg::STAT_FULL;
                            state_next    = cat_pkg::S_IDLE;
                        end
                    end
                    cat_pkg::CMD_REMOVE: begin
                        if (slot_match || last_slot) begin
                            if (slot_match) begin
                                valid_next[idx_reg] = 1'b0;
                            end
                            m_valid_next  = 1'b1;
                            m_status_next = cat_pkg::STAT_OK;
                            state_next    = cat_pkg::S_IDLE;
                        end
                    end
                    default: begin
                        found_next = found_reg || slot_match;
                        used_next  = used_reg || slot_used;
                        if (last_slot) begin
                            m_valid_next   = 1'b1;
                            m_status_next  = cat_pkg::STAT_OK;
                            m_allowed_next = found_next || !used_next;
                            state_next     = cat_pkg::S_IDLE;
                        end
                    end
                endcase
            end
            default: begin
                state_next = cat_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= cat_pkg::S_IDLE;
            valid_reg   <= '0;
            init_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                init_reg <= cfg_wdata;
            end
        end
    end

    // the word under the next scan pointer is registered together with the pointer
    always_ff @(posedge aclk) begin
        idx_reg       <= idx_next;
        cmd_reg       <= cmd_next;
        num_reg       <= num_next;
        found_reg     <= found_next;
        used_reg      <= used_next;
        m_status_reg  <= m_status_next;
        m_allowed_reg <= m_allowed_next;
        rd_word_reg   <= table_reg[idx_next];
        if (tbl_we) begin
            table_reg[idx_reg] <= num_reg;
        end
    end

    // a refused beat answers not initialised on the next cycle
    a_not_init: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !init_reg |=> m_valid_reg && (m_status_reg == cat_pkg::STAT_NOT_INIT))
        else $error("refused beat did not report not initialised");

    // allowed is only ever set on an ok result
    a_allowed_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_allowed_reg |-> (m_status_reg == cat_pkg::STAT_OK))
        else $error("allowed set with a non-ok status");

    // no result is held while a scan is running
    a_scan_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == cat_pkg::S_SCAN) |-> !m_valid_reg)
        else $error("result pending during scan");

    // a full report only follows an add that found every slot taken
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == cat_pkg::S_SCAN) && (cmd_reg == cat_pkg::CMD_ADD) && slot_used
            && last_slot |=> (m_status_reg == cat_pkg::STAT_FULL) && (&valid_reg))
        else $error("table full reported with a free slot");

endmodule

### tb/caller_allowlist_table_tb.sv
// self-checking testbench for the caller allow-list table: directed rows, then random phases
`timescale 1ns / 1ps

module caller_allowlist_table_tb;

    localparam int IDLE_LIMIT = 2000;
    localparam int TAIL_CYCLES = 20;

    typedef struct {
        cat_pkg::status_t status;
        logic             allowed;
    } verdict_t;

    typedef struct {
        bit               cfg_before;
        logic             cfg_val;
        cat_pkg::cmd_t    cmd;
        logic [31:0]      number;
        bit               typed;
        cat_pkg::status_t status;
        logic             allowed;
    } dir_row_t;

    logic                          aclk;
    logic                          aresetn;
    logic                          cfg_we;
    logic                          cfg_wdata;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [cat_pkg::S_TDATA_W-1:0] s_tdata;   // cmd[1:0], number[33:2], zero pad
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [cat_pkg::M_TDATA_W-1:0] m_tdata;   // status[1:0], allowed[2], zero pad

    // predictor copy of the block state
    logic [cat_pkg::NUM_W-1:0] slot_words [cat_pkg::TABLE_ENTRIES];
    logic             init_copy;
    verdict_t         pending_verdicts [$];
    logic [31:0]      num_pool [10];

    int  error_count = 0;
    int  idle_cycles = 0;
    int  stall_left = 0;
    bit  rx_steady = 1'b0;
    bit  tx_steady = 1'b0;

    dir_row_t dir_rows [24] = '{
        // refused before the register is set
        '{1'b0, 1'b0, cat_pkg::CMD_ADD,    32'hFFFF_FFFF, 1'b1, cat_pkg::STAT_NOT_INIT, 1'b0},
        '{1'b0, 1'b0, cat_pkg::CMD_REMOVE, 32'h0000_0001, 1'b1, cat_pkg::STAT_NOT_INIT, 1'b0},
        '{1'b0, 1'b0, cat_pkg::CMD_CHECK,  32'h0000_0000, 1'b1, cat_pkg::STAT_NOT_INIT, 1'b0},
        '{1'b0, 1'b0, cat_pkg::CMD_CLEAR,  32'h0000_0000, 1'b1, cat_pkg::STAT_NOT_INIT, 1'b0},
        // empty table allows anything, zero numbers are invalid, then every slot is filled
        '{1'b1, 1'b1, cat_pkg::CMD_CHECK,  32'h0000_0005, 1'b1, cat_pkg::STAT_OK,       1'b1},
        '{1'b0, 1'b0, cat_pkg::CMD_ADD,    32'h0000_0000, 1'b1, cat_pkg::STAT_INVALID,  1'b0},
        '{1'b0, 1'b0, cat_pkg::CMD_REMOVE, 32'h0000_0000, 1'b1, cat_pkg::STAT_INVALID,  1'b0},
        '{1'b0, 1'b0, cat_pkg::CMD_CHECK,  32'h0000_0000, 1'b1, cat_pkg::STAT_INVALID,  1'b0},
        '{1'b0, 1'b0, cat_pkg::CMD_ADD,    32'hFFFF_FFFF, 1'b0, cat_pkg::STAT_OK,       1'b0},
        '{1'b0, 1'b0, cat_pkg::CMD_ADD,    32'h0000_0001, 1'b0, cat_pkg::STAT_OK,       1'b0},
        '{1'b0, 1'b0, cat_pkg::CMD_ADD,    32'h8000_0000, 1'b0, cat_pkg::STAT_OK,       1'b0},
        '{1'b0, 1'b0, cat_pkg::CMD_ADD,    32'hFFFF_FFFF, 1'b0, cat_pkg::STAT_OK,       1'b0},
        '{1'b0, 1'b0, cat_pkg::CMD_ADD,    32'h0000_0002, 1'b0, cat_pkg::STAT_OK,       1'b0},
        '{1'b0, 1'b0, cat_pkg::CMD_ADD,    32'h0000_0003, 1'b0, cat_pkg::STAT_OK,       1'b0},
        '{1'b0, 1'b0, cat_pkg::CMD_ADD,    32'h0000_0004, 1'b0, cat_pkg::STAT_OK,       1'b0},
        '{1'b0, 1'b0, cat_pkg::CMD_ADD,    32'h0000_0005, 1'b0, cat_pkg::STAT_OK,       1'b0},
        // every slot taken
        '{1'b0, 1'b0, cat_pkg::CMD_ADD,    32'h0000_0006, 1'b1, cat_pkg::STAT_FULL,     1'b0},
        '{1'b0, 1'b0, cat_pkg::CMD_CHECK,  32'h0000_0006, 1'b0, cat_pkg::STAT_OK,       1'b0},
        // duplicate: only the lowest copy goes; then an absent remove, a refill and a clear
        '{1'b0, 1'b0, cat_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 1'b0, cat_pkg::STAT_OK,       1'b0},
        '{1'b0, 1'b0, cat_pkg::CMD_CHECK,  32'hFFFF_FFFF, 1'b0, cat_pkg::STAT_OK,       1'b0},
        '{1'b0, 1'b0, cat_pkg::CMD_REMOVE, 32'h0000_004D, 1'b0, cat_pkg::STAT_OK,       1'b0},
        '{1'b0, 1'b0, cat_pkg::CMD_ADD,    32'h0000_0006, 1'b0, cat_pkg::STAT_OK,       1'b0},
        '{1'b0, 1'b0, cat_pkg::CMD_CLEAR,  32'hFFFF_FFFF, 1'b0, cat_pkg::STAT_OK,       1'b0},
        '{1'b0, 1'b0, cat_pkg::CMD_CHECK,  32'h0000_0009, 1'b1, cat_pkg::STAT_OK,       1'b1}
    };

    caller_allowlist_table dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // applies one command to the predictor table and returns its verdict
    function automatic verdict_t table_verdict(input cat_pkg::cmd_t c, input logic [31:0] n);
        verdict_t v;
        bit       done;
        bit       found;
        bit       used;
        v.status  = cat_pkg::STAT_OK;
        v.allowed = 1'b0;
        done  = 1'b0;
        found = 1'b0;
        used  = 1'b0;
        if (!init_copy) begin
            v.status = cat_pkg::STAT_NOT_INIT;
        end else if (c == cat_pkg::CMD_CLEAR) begin
            foreach (slot_words[i]) slot_words[i] = '0;
        end else if (n == '0) begin
            v.status = cat_pkg::STAT_INVALID;
        end else if (c == cat_pkg::CMD_ADD) begin
            v.status = cat_pkg::STAT_FULL;
            foreach (slot_words[i]) begin
                if (!done && slot_words[i] == '0) begin
                    slot_words[i] = n;
                    v.status = cat_pkg::STAT_OK;
                    done = 1'b1;
                end
            end
        end else if (c == cat_pkg::CMD_REMOVE) begin
            foreach (slot_words[i]) begin
                if (!done && slot_words[i] == n) begin
                    slot_words[i] = '0;
                    done = 1'b1;
                end
            end
        end else begin
            foreach (slot_words[i]) begin
                if (slot_words[i] == n) found = 1'b1;
                if (slot_words[i] != '0) used = 1'b1;
            end
            v.allowed = found || !used;
        end
        return v;
    endfunction

    // mostly no gap, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic logic [31:0] pick_number();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return num_pool[$urandom_range(0, 9)];
        if (r < 90) return $urandom;
        if (r < 95) return 32'h0000_0000;
        return 32'hFFFF_FFFF;
    endfunction

    function automatic cat_pkg::cmd_t pick_cmd();
        int r;
        r = $urandom_range(0, 99);
        if (r < 36) return cat_pkg::CMD_ADD;
        if (r < 62) return cat_pkg::CMD_REMOVE;
        if (r < 95) return cat_pkg::CMD_CHECK;
        return cat_pkg::CMD_CLEAR;
    endfunction

    task automatic send_command(input cat_pkg::cmd_t c, input logic [31:0] n, input int gap,
                                input bit typed, input verdict_t fixed);
        verdict_t v;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(cat_pkg::S_TDATA_W - cat_pkg::NUM_W - 2){1'b0}}, n, c};
        do @(posedge aclk); while (!s_tready);
        v = table_verdict(c, n);
        pending_verdicts.push_back(typed ? fixed : v);
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_verdicts.size() != 0) @(posedge aclk);
    endtask

    task automatic write_initialized(input logic val);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        init_copy = val;
    endtask

    // result side: check, watchdog and back-pressure
    always @(posedge aclk) begin
        verdict_t want;
        if (m_tvalid && m_tready) begin
            if (pending_verdicts.size() == 0) begin
                $display("%0t: unexpected result beat, tdata %h", $time, m_tdata);
                error_count++;
            end else begin
                want = pending_verdicts.pop_front();
                if (m_tdata[1:0] !== want.status) begin
                    $display("%0t: status expected %0d, got %0d", $time,
                             want.status, m_tdata[1:0]);
                    error_count++;
                end
                if (m_tdata[2] !== want.allowed) begin
                    $display("%0t: allowed expected %0d, got %0d", $time,
                             want.allowed, m_tdata[2]);
                    error_count++;
                end
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("caller_allowlist_table_tb: done, errors");
                $finish;
            end
        end
        if ($urandom_range(0, 299) == 0) rx_steady = !rx_steady;
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
            if (!rx_steady) stall_left = pick_gap();
        end
    end

    initial begin
        verdict_t fixed;
        logic     phase_init [8];
        int       count;
        phase_init = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
        foreach (slot_words[i]) slot_words[i] = '0;
        init_copy = 1'b0;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_we    <= 1'b0;
        cfg_wdata <= 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].cfg_before) write_initialized(dir_rows[i].cfg_val);
            fixed.status  = dir_rows[i].status;
            fixed.allowed = dir_rows[i].allowed;
            send_command(dir_rows[i].cmd, dir_rows[i].number, pick_gap(),
                         dir_rows[i].typed, fixed);
        end

        foreach (phase_init[p]) begin
            write_initialized(phase_init[p]);
            // small values collide often, so adds, hits and duplicates are common
            foreach (num_pool[k]) num_pool[k] = (k < 5) ? $urandom_range(1, 12) : $urandom;
            count = phase_init[p] ? 330 : 120;
            for (int j = 0; j < count; j++) begin
                if ($urandom_range(0, 99) == 0) tx_steady = !tx_steady;
                if ($urandom_range(0, 149) == 0) drain_results();
                send_command(pick_cmd(), pick_number(), tx_steady ? 0 : pick_gap(),
                             1'b0, fixed);
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("caller_allowlist_table_tb: done, clean");
        end else begin
            $display("caller_allowlist_table_tb: done, errors");
        end
        $finish;
    end

endmodule

### filelist.f
sv/cat_pkg.sv
sv/caller_allowlist_table.sv
tb/caller_allowlist_table_tb.sv
